>>> rtl/core/ipe_pkg.sv
// shared types and codes for the infix precedence evaluator
package ipe_pkg;

  localparam int OP_W = 3;

  localparam logic [OP_W-1:0] OP_PLUS   = 3'd0;
  localparam logic [OP_W-1:0] OP_MINUS  = 3'd1;
  localparam logic [OP_W-1:0] OP_MUL    = 3'd2;
  localparam logic [OP_W-1:0] OP_DIV    = 3'd3;
  localparam logic [OP_W-1:0] OP_EQUALS = 3'd4;

  typedef enum logic [1:0] {
    MUL_NONE = 2'd0,
    MUL_MUL  = 2'd2,
    MUL_DIV  = 2'd3
  } mul_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_NEG_A,
    ST_NEG_B,
    ST_DIV,
    ST_NEG_Q,
    ST_FOLD
  } state_t;

endpackage

>>> rtl/core/infix_precedence_evaluator_core.sv
// infix evaluator core: two-level precedence over a shared add/subtract unit
//
// input channel (s_*): one beat per (number, following operator) item; the
// number is in s_tdata, the operator code in s_tuser (0 plus, 1 minus,
// 2 multiply, 3 divide, 4 equals; 5 to 7 act as plus)
// output channel (m_*): one beat per equals, carrying the wrapped sum in
// m_tdata and the sticky divide-by-zero flag in m_tuser
//
// all arithmetic runs through one WORD_BITS+1 bit adder/subtractor driven by
// a small sequencer; s_tready is high only in the idle state
//   plus / minus / equals item : accept, fold
//   item after a pending '*'   : accept, shift-add (1 bit/cycle), fold
//   item after a pending '/'   : accept, two operand negates,
//                                restoring divide 1 bit/cycle, quotient sign, fold
//   divide by zero skips the divider: accept, fold
//
// reset clears the sum, term, sign, pending operator, error flag and the
// output register; the result beat waits in its register until m_tready,
// and an equals item that finds the register still full holds in the fold
// step until the receiver takes the previous result
module infix_precedence_evaluator_core #(
  parameter int WORD_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [31:0]              s_tdata,   // [31:0] operand_value
  input  logic [ipe_pkg::OP_W-1:0] s_tuser,   // [2:0] operator_code
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [31:0]              m_tdata,   // [31:0] expression_result
  output logic [0:0]               m_tuser    // [0] divide_error
);
  import ipe_pkg::*;

  localparam int W     = WORD_BITS;
  localparam int CNT_W = $clog2(WORD_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_BITS - 1);

  state_t state, state_next;

  // architectural state
  logic [W-1:0]    sum;
  logic [W-1:0]    term;        // product term, then the finished term
  logic            sign_minus;
  mul_op_t         pend;
  logic            err;
  logic [OP_W-1:0] op;

  // shared unit working registers
  logic [W-1:0]     acc;        // product accumulator / partial remainder
  logic [W-1:0]     opb;        // multiplicand / divisor
  logic [W-1:0]     opc;        // multiplier / dividend shifting into quotient
  logic [CNT_W-1:0] cnt;
  logic             qneg;

  // the one adder/subtractor
  logic [W:0] alu_a, alu_b, alu_y;
  logic       alu_sub;
  assign alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

  // input number wrapped to the word size
  logic signed [63:0] in_ext;
  logic [W-1:0]       in_val;
  assign in_ext = 64'(signed'(s_tdata));
  assign in_val = in_ext[W-1:0];

  // final sum sign-extended to the port width
  logic signed [63:0] sum_ext;
  assign sum_ext = 64'(signed'(alu_y[W-1:0]));

  logic accept, op_is_mul, op_is_eq, out_free;
  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign op_is_mul = (op == OP_MUL) || (op == OP_DIV);
  assign op_is_eq  = (op == OP_EQUALS);
  assign out_free  = !m_tvalid || m_tready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (pend == MUL_MUL) begin
            state_next = ST_MUL;
          end else if (pend == MUL_DIV && in_val != '0) begin
            state_next = ST_NEG_A;
          end else begin
            state_next = ST_FOLD;
          end
        end
      end
      ST_MUL:   if (cnt == CNT_LAST) state_next = ST_FOLD;
      ST_NEG_A: state_next = ST_NEG_B;
      ST_NEG_B: state_next = ST_DIV;
      ST_DIV:   if (cnt == CNT_LAST) state_next = ST_NEG_Q;
      ST_NEG_Q: state_next = ST_FOLD;
      ST_FOLD: begin
        // an equals waits for the output register to drain
        if (op_is_mul || !op_is_eq || out_free) state_next = ST_IDLE;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // shared unit operand selection
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state)
      ST_MUL: begin
        alu_a = {1'b0, acc};
        alu_b = {1'b0, opb};
      end
      ST_NEG_A: begin
        alu_b   = {1'b0, opc};
        alu_sub = 1'b1;
      end
      ST_NEG_B: begin
        alu_b   = {1'b0, opb};
        alu_sub = 1'b1;
      end
      ST_DIV: begin
        alu_a   = {acc, opc[W-1]};
        alu_b   = {1'b0, opb};
        alu_sub = 1'b1;
      end
      ST_NEG_Q: begin
        alu_b   = {1'b0, opc};
        alu_sub = 1'b1;
      end
      ST_FOLD: begin
        alu_a   = {1'b0, sum};
        alu_b   = {1'b0, term};
        alu_sub = sign_minus;
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      sum        <= '0;
      term       <= '0;
      sign_minus <= 1'b0;
      pend       <= MUL_NONE;
      err        <= 1'b0;
      m_tvalid   <= 1'b0;
      m_tdata    <= '0;
      m_tuser    <= '0;
    end else begin
      state <= state_next;

      // result beat loads on a finished equals, else drops once taken
      if (state == ST_FOLD && !op_is_mul && op_is_eq && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            op   <= s_tuser;
            acc  <= '0;
            cnt  <= '0;
            qneg <= term[W-1] ^ in_val[W-1];
            if (pend == MUL_MUL) begin
              opb <= term;
              opc <= in_val;
            end else if (pend == MUL_DIV) begin
              opb <= in_val;
              opc <= term;
              if (in_val == '0) begin
                // divide by zero: zero term, sticky flag
                term <= '0;
                err  <= 1'b1;
              end
            end else begin
              term <= in_val;
            end
          end
        end
        ST_MUL: begin
          if (opc[0]) acc <= alu_y[W-1:0];
          opb <= opb << 1;
          opc <= opc >> 1;
          cnt <= cnt + 1'b1;
          if (cnt == CNT_LAST) begin
            term <= opc[0] ? alu_y[W-1:0] : acc;
          end
        end
        ST_NEG_A: if (opc[W-1]) opc <= alu_y[W-1:0];
        ST_NEG_B: if (opb[W-1]) opb <= alu_y[W-1:0];
        ST_DIV: begin
          // restoring step: keep the difference when no borrow
          if (!alu_y[W]) begin
            acc <= alu_y[W-1:0];
            opc <= {opc[W-2:0], 1'b1};
          end else begin
            acc <= alu_a[W-1:0];
            opc <= {opc[W-2:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
        end
        ST_NEG_Q: term <= qneg ? alu_y[W-1:0] : opc;
        ST_FOLD: begin
          if (op_is_mul) begin
            pend <= (op == OP_MUL) ? MUL_MUL : MUL_DIV;
          end else if (!op_is_eq) begin
            sum        <= alu_y[W-1:0];
            term       <= '0;
            pend       <= MUL_NONE;
            sign_minus <= (op == OP_MINUS);
          end else if (out_free) begin
            m_tdata    <= sum_ext[31:0];
            m_tuser    <= err;
            sum        <= '0;
            term       <= '0;
            pend       <= MUL_NONE;
            sign_minus <= 1'b0;
            err        <= 1'b0;
          end
        end
        default: begin
          cnt <= '0;
        end
      endcase
    end
  end

endmodule
